// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked implication checks with an active-low reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: the consequent must hold when the antecedent does.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/bdd_pkg.sv
// ---------------------------------------------------------------------------
// bdd_pkg
// Types, constants and the nibble divide step of the decimal digit converter.
// ---------------------------------------------------------------------------
package bdd_pkg;

	localparam int unsigned NIB_W      = 4;
	localparam int unsigned DIGIT_W    = 4;
	localparam int unsigned POS_W      = 6;
	localparam int unsigned MAX_DIGITS = 39;
	localparam int unsigned RADIX      = 10;
	localparam logic [NIB_W-1:0] NIB_MASK = 4'hF;

	// Reciprocal of ten scaled by 2^11; exact for dividends below 1024.
	localparam logic [7:0] RECIP_TEN  = 8'd205;
	localparam int unsigned RECIP_SH  = 11;

	// Word handed from one cell to the next every cycle.
	typedef struct packed {
		logic             vld;
		logic             zero;
		logic [NIB_W-1:0] rem;
	} bdd_link_t;

	// Result of one long-division step on a nibble.
	typedef struct packed {
		logic [NIB_W-1:0] quo;
		logic [NIB_W-1:0] rem;
	} bdd_step_t;

	// Divides (rem_in * 16 + nib) by ten. The dividend stays below 160.
	function automatic bdd_step_t div_step(input logic [NIB_W-1:0] rem_in,
		input logic [NIB_W-1:0] nib);
		logic [7:0]  dvd;
		logic [15:0] prod;
		logic [7:0]  quo;
		logic [7:0]  back;
		logic [7:0]  rem;
		bdd_step_t   res;
		dvd  = {rem_in, nib};
		prod = 16'(dvd) * 16'(RECIP_TEN);
		quo  = 8'(prod >> RECIP_SH);
		back = 8'(quo * 8'(RADIX));
		rem  = dvd - back;
		res.quo = quo[NIB_W-1:0] & NIB_MASK;
		res.rem = rem[NIB_W-1:0] & NIB_MASK;
		return res;
	endfunction

endpackage

// File: hw/rtl/bdd_cell.sv
// ---------------------------------------------------------------------------
// bdd_cell
// One nibble of the running quotient; does one long-division step per cycle while its input link is valid.
// ---------------------------------------------------------------------------
module bdd_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic [bdd_pkg::NIB_W-1:0]         load_nib,
	input  logic                              flush,
	input  bdd_pkg::bdd_link_t                link_in,
	output bdd_pkg::bdd_link_t                link_out
);

	logic [bdd_pkg::NIB_W-1:0] nib_q;
	logic                      vld_q;
	logic                      zero_q;
	logic [bdd_pkg::NIB_W-1:0] rem_q;
	bdd_pkg::bdd_step_t        step;

	// Divide the incoming remainder and the held nibble by ten.
	always_comb begin
		step = bdd_pkg::div_step(link_in.rem, nib_q);
	end

	// The held nibble is replaced by its quotient on every step.
	always_ff @(posedge clk) begin
		if (load) begin
			nib_q <= load_nib;
		end else if (link_in.vld) begin
			nib_q <= step.quo;
		end
	end

	// Remainder and zero flag move right one cell per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (flush || load) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= link_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (link_in.vld) begin
			rem_q  <= step.rem;
			zero_q <= link_in.zero & (step.quo == '0);
		end
	end

	assign link_out = '{vld: vld_q, zero: zero_q, rem: rem_q};

endmodule

// File: hw/rtl/binary_to_decimal_digits.sv
// ---------------------------------------------------------------------------
// binary_to_decimal_digits
// Converts an unsigned binary value to decimal digits, least significant first.
// ---------------------------------------------------------------------------
// Usage:
//   Drive value_high/value_low and raise start while busy is low; the word is
//   taken at that edge. Only the low VALUE_BYTES*8 bits of {value_high,
//   value_low} take part. busy stays high until the last digit has been shown.
//   Digits come out on digit/digit_position/last, each for exactly one cycle
//   marked by digit_valid, units first, one per cycle with no gaps. The
//   receiver cannot stall, so it must take a digit in the cycle it is shown.
// Timing:
//   A row of 2*VALUE_BYTES nibble cells runs repeated divisions by ten in a
//   wave: each cycle every active cell divides its nibble and passes the
//   remainder right. The first digit leaves the last cell once the wave has
//   crossed the whole row, then one digit per cycle. The length of the cell
//   row sets the latency; one item is in flight.
// Reset:
//   arst_n clears busy and all valid bits; no digit is shown after reset.
// ---------------------------------------------------------------------------
module binary_to_decimal_digits #(
	parameter int unsigned VALUE_BYTES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [63:0]                   value_high,
	input  logic [63:0]                   value_low,
	output logic                          digit_valid,
	output logic [bdd_pkg::DIGIT_W-1:0]   digit,
	output logic [bdd_pkg::POS_W-1:0]     digit_position,
	output logic                          last
);

	localparam int unsigned NCELLS = VALUE_BYTES * 2;

	logic                          run_q;
	logic [bdd_pkg::POS_W-1:0]     pos_q;
	logic                          accept;
	logic                          finish;
	logic [127:0]                  full;
	bdd_pkg::bdd_link_t            link [NCELLS+1];

	assign full   = {value_high, value_low};
	assign accept = start & ~run_q;
	assign busy   = run_q;

	// The head of the row starts each division with no remainder.
	assign link[0] = '{vld: run_q, zero: 1'b1, rem: '0};

	// Cell 0 holds the most significant nibble.
	for (genvar i = 0; i < NCELLS; i++) begin : g_cell
		bdd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.load     (accept),
			.load_nib (full[(NCELLS-1-i)*bdd_pkg::NIB_W +: bdd_pkg::NIB_W]),
			.flush    (finish),
			.link_in  (link[i]),
			.link_out (link[i+1])
		);
	end

	// Digit outputs come straight from the last cell.
	assign digit_valid    = link[NCELLS].vld & run_q;
	assign digit          = link[NCELLS].rem;
	assign digit_position = pos_q;
	assign last           = link[NCELLS].zero |
		(pos_q == bdd_pkg::POS_W'(bdd_pkg::MAX_DIGITS - 1));
	assign finish         = digit_valid & last;

	// Run control and digit position counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			pos_q <= '0;
		end else if (accept) begin
			run_q <= 1'b1;
			pos_q <= '0;
		end else if (finish) begin
			run_q <= 1'b0;
			pos_q <= '0;
		end else if (digit_valid) begin
			pos_q <= pos_q + bdd_pkg::POS_W'(1);
		end
	end

endmodule

// File: hw/rtl/bdd_checker.sv
// ---------------------------------------------------------------------------
// bdd_checker
// Port-level checks on the digit stream of the decimal digit converter.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bdd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        digit_valid,
	input  logic [3:0]  digit,
	input  logic [5:0]  digit_position,
	input  logic        last
);

	// Every digit is decimal and appears only while a word is in flight.
	`ASSERT_IMPLY(a_digit_range, clk, arst_n, digit_valid, (digit < 4'd10) && busy, "digit out of range or shown while idle")

	// A digit that is not the last is followed at once by the next position.
	`ASSERT_NEXT(a_digit_seq, clk, arst_n, digit_valid && !last, digit_valid && (digit_position == $past(digit_position) + 6'd1), "digit stream broken")

	// The last digit ends the run.
	`ASSERT_NEXT(a_last_ends, clk, arst_n, digit_valid && last, !busy && !digit_valid, "block still busy after last digit")

	// A new word starts a run with no stale digit showing.
	`ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy && !digit_valid, "accepted word did not start a clean run")

	// The first digit of a run is the units digit.
	`ASSERT_NEXT(a_first_units, clk, arst_n, start && !busy, digit_position == 6'd0, "run did not start at the units digit")

endmodule

bind binary_to_decimal_digits bdd_checker u_bdd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.digit_valid    (digit_valid),
	.digit          (digit),
	.digit_position (digit_position),
	.last           (last)
);
